### hdl/espf_pkg.sv
package espf_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int HEADER_LEN   = 2;
	localparam int PAIR_COUNT   = (NUM_CHANNELS + 1) / 2;
	localparam int PACKET_LEN   = 3 * PAIR_COUNT + HEADER_LEN;
	localparam int CH_W         = $clog2(NUM_CHANNELS);
	localparam int IDX_W        = $clog2(PACKET_LEN);
	localparam int ID_LEN       = 9;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);

	localparam logic [2:0] AUX_SEL_ID = 3'd0;
	localparam logic [2:0] AUX_SEL_SW = 3'd4;
	localparam logic [7:0] SYNC_MASK  = 8'h80;

	typedef struct packed {
		logic [9:0] sample;
		logic       frame_start;
		logic [3:0] switches;
	} sample_req_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
	} byte_req_t;

	typedef logic [PACKET_LEN-1:0][7:0] packet_t;

	function automatic logic [7:0] id_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0: c = 8'h6D;
			4'd1: c = 8'h45;
			4'd2: c = 8'h45;
			4'd3: c = 8'h47;
			4'd4: c = 8'h76;
			4'd5: c = 8'h31;
			4'd6: c = 8'h2E;
			4'd7: c = 8'h30;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### hdl/espf_front.sv
module espf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  espf_pkg::sample_req_t item,
	input  logic                  push,
	output logic                  full,
	output logic                  q_wr,
	output espf_pkg::packet_t     q_data,
	input  logic                  q_full
);
	import espf_pkg::*;

	logic [CH_W-1:0]                ch_q;
	logic [CH_W-1:0]                ch;
	logic [PAIR_COUNT-1:0][6:0]     lo_even_q, lo_even_d;
	logic [PAIR_COUNT-1:0][6:0]     lo_odd_q, lo_odd_d;
	logic [PAIR_COUNT-1:0][2:0]     hi_even_q, hi_even_d;
	logic [PAIR_COUNT-1:0][2:0]     hi_odd_q, hi_odd_d;
	logic [5:0]                     pkt_cnt_q;
	logic [3:0]                     id_pos_q, id_pos_d, pos, pos_inc;
	logic [7:0]                     aux;
	logic                           accept;
	logic                           complete;

	always_comb begin
		accept   = push && !q_full;
		full     = q_full;
		ch       = item.frame_start ? '0 : ch_q;
		complete = accept && (ch == CH_W'(NUM_CHANNELS - 1));

		// merge the incoming sample into its pair slot
		lo_even_d = lo_even_q;
		lo_odd_d  = lo_odd_q;
		hi_even_d = hi_even_q;
		hi_odd_d  = hi_odd_q;
		for (int p = 0; p < PAIR_COUNT; p++) begin
			if (ch == CH_W'(2 * p)) begin
				lo_even_d[p] = item.sample[6:0];
				hi_even_d[p] = item.sample[9:7];
			end
			if ((2 * p + 1 < NUM_CHANNELS) && (ch == CH_W'(2 * p + 1))) begin
				lo_odd_d[p] = item.sample[6:0];
				hi_odd_d[p] = item.sample[9:7];
			end
		end

		// aux byte: ID string, switches or zero
		pos      = (id_pos_q >= 4'(ID_LEN)) ? 4'd0 : id_pos_q;
		pos_inc  = pos + 4'd1;
		id_pos_d = id_pos_q;
		unique case (pkt_cnt_q[2:0])
			AUX_SEL_ID: begin
				aux      = id_char(pos);
				id_pos_d = ((aux == 8'h00) || (pos_inc >= 4'(ID_LEN))) ? 4'd0 : pos_inc;
			end
			AUX_SEL_SW: aux = {4'b0000, item.switches};
			default:    aux = 8'h00;
		endcase

		q_data[0] = {1'b0, pkt_cnt_q, aux[7]};
		q_data[1] = {1'b0, aux[6:0]};
		for (int p = 0; p < PAIR_COUNT; p++) begin
			q_data[HEADER_LEN + 3 * p] = {1'b0, lo_even_d[p]};
			if (2 * p + 1 < NUM_CHANNELS) begin
				q_data[HEADER_LEN + 3 * p + 1] = {1'b0, lo_odd_d[p]};
				q_data[HEADER_LEN + 3 * p + 2] = {1'b0, hi_even_d[p], 1'b0, hi_odd_d[p]};
			end else begin
				q_data[HEADER_LEN + 3 * p + 1] = 8'h00;
				q_data[HEADER_LEN + 3 * p + 2] = {1'b0, hi_even_d[p], 4'b0000};
			end
		end
		q_data[PACKET_LEN-1] = q_data[PACKET_LEN-1] | SYNC_MASK;
		q_wr = complete;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q      <= '0;
			pkt_cnt_q <= '0;
			id_pos_q  <= '0;
		end else if (accept) begin
			ch_q <= complete ? '0 : ch + CH_W'(1);
			if (complete) begin
				pkt_cnt_q <= pkt_cnt_q + 6'd1;
				id_pos_q  <= id_pos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_even_q <= lo_even_d;
			lo_odd_q  <= lo_odd_d;
			hi_even_q <= hi_even_d;
			hi_odd_q  <= hi_odd_d;
		end
	end

endmodule

### hdl/espf_queue.sv
module espf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  espf_pkg::packet_t wdata,
	output logic              full,
	input  logic              rd,
	output espf_pkg::packet_t rdata,
	output logic              empty
);
	import espf_pkg::*;

	packet_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	always_comb begin
		full  = (count_q == (QPTR_W + 1)'(QDEPTH));
		empty = (count_q == '0);
		rdata = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr && !full)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd && !empty)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({wr && !full, rd && !empty})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### hdl/espf_back.sv
module espf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  espf_pkg::packet_t   head,
	input  logic                q_empty,
	output logic                q_rd,
	output espf_pkg::byte_req_t result,
	output logic                empty,
	input  logic                pop
);
	import espf_pkg::*;

	logic [IDX_W-1:0] idx_q;
	byte_req_t        out_q;
	logic             out_valid_q;
	logic             load;
	logic             last;

	always_comb begin
		load   = !q_empty && (!out_valid_q || pop);
		last   = (idx_q == IDX_W'(PACKET_LEN - 1));
		q_rd   = load && last;
		empty  = !out_valid_q;
		result = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? '0 : idx_q + IDX_W'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.packet_byte <= head[idx_q];
			out_q.last_byte   <= last;
		end
	end

endmodule

### hdl/eeg_sample_packet_framer.sv
// Sample packet framer. Push one 10-bit sample per request, channel 0 first;
// frame_start restarts the channel count. Once the last channel of a frame is
// taken, the block queues a complete packet (two header bytes holding the
// 6-bit packet counter and an aux byte, then three bytes per channel pair,
// sync bit set in the final byte) and pops it out one byte per request with
// last_byte marking the end. A sample request is taken in any cycle in which
// full is low; full is high only while the packet queue (two packets deep)
// holds two packets. The byte serializer delivers at most one byte per cycle, as
// pop takes them, and the front keeps taking samples while a packet drains,
// until the queue fills. A completed packet is written into the packet queue,
// and its first byte is then loaded into the registered output byte, from
// which it is popped.
module eeg_sample_packet_framer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  espf_pkg::sample_req_t item,
	input  logic                  push,
	output logic                  full,
	output espf_pkg::byte_req_t   result,
	output logic                  empty,
	input  logic                  pop
);
	import espf_pkg::*;

	// front to queue
	logic    q_wr;
	packet_t q_wdata;
	logic    q_full;

	// queue to back
	logic    q_rd;
	packet_t q_head;
	logic    q_empty;

	// Front: track channel slots, build the header and assemble packets.
	espf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.q_wr   (q_wr),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	// Hold finished packets so the front keeps taking samples while the
	// back is still draining bytes.
	espf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_head),
		.empty  (q_empty)
	);

	// Back: serialize the head packet into a registered byte stream.
	espf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

### tb/sv/tb_top.sv
`default_nettype none

// Testbench for the sample packet framer.
// Samples go in as queue requests (push/full); packet bytes come back as queue
// requests (empty/pop). A local predictor tracks the channel count, the packet
// store, the packet counter and the ID text position. It queues the bytes that
// each completing sample must produce, and a checker compares every popped
// byte against the oldest queued byte.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import espf_pkg::*;

	localparam int TEXT_LEN    = 9;
	localparam int DRAIN_WAIT  = 30;
	// directed tests send 27 samples, random traffic tops the run up to ~400
	localparam int RANDOM_ITEMS = 372;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	sample_req_t item   = '0;
	logic        push   = 1'b0;
	logic        full;
	byte_req_t   result;
	logic        empty;
	logic        pop    = 1'b0;

	// Expected bytes still to come, oldest first
	byte_req_t   expected_bytes[$];

	// Predictor state
	logic [7:0]  frame_store [PACKET_LEN];
	int          next_channel;
	logic [5:0]  packet_number;
	logic [3:0]  text_index;
	logic [7:0]  id_text [TEXT_LEN] = '{8'h6D, 8'h45, 8'h45, 8'h47, 8'h76,
	                                    8'h31, 8'h2E, 8'h30, 8'h00};

	// Idling on both sides; cleared for stretches of back-to-back traffic
	logic        idle_on = 1'b1;

	int          samples_sent;
	int          packets_predicted;
	int          bytes_checked;
	int          mismatches;
	int          switch_packets;
	int          text_packets;

	eeg_sample_packet_framer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

	always #5 clk = ~clk;

	// Fixed time limit: the slowest legal run is well under a tenth of this
	initial begin : watchdog
		#2ms;
		$display("Timeout with %0d bytes outstanding", expected_bytes.size());
		$display("FAILED: results differ");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch: %s", msg);
	endtask

	// Advance the predictor by one accepted sample and queue the packet it
	// completes, if any.
	task automatic predict_packet(input sample_req_t req);
		logic [6:0] low7;
		logic [2:0] top3;
		int         base;
		logic [7:0] aux;
		byte_req_t  b;
		low7 = req.sample[6:0];
		top3 = req.sample[9:7];

		// Restart the channel count on a frame start
		if (req.frame_start || next_channel >= NUM_CHANNELS)
			next_channel = 0;

		base = 3 * (next_channel / 2) + HEADER_LEN;
		if (base + 2 < PACKET_LEN) begin
			if (next_channel % 2 == 1) begin
				frame_store[base + 1] = {1'b0, low7};
				frame_store[base + 2] = frame_store[base + 2] | {5'b0, top3};
			end else begin
				// Even channel rewrites the shared byte, clearing the odd bits
				frame_store[base]     = {1'b0, low7};
				frame_store[base + 2] = {1'b0, top3, 4'b0};
			end
		end

		if (next_channel + 1 < NUM_CHANNELS) begin
			next_channel++;
			return;
		end
		next_channel = 0;

		// Pick the aux byte from the low counter bits
		if (packet_number[2:0] == AUX_SEL_ID) begin
			if (text_index >= TEXT_LEN)
				text_index = '0;
			aux = id_text[text_index];
			text_index = text_index + 4'd1;
			if (aux == 8'h00 || text_index >= TEXT_LEN)
				text_index = '0;
			text_packets++;
		end else if (packet_number[2:0] == AUX_SEL_SW) begin
			aux = {4'b0, req.switches};
			switch_packets++;
		end else begin
			aux = 8'h00;
		end

		frame_store[0] = {1'b0, packet_number, aux[7]};
		frame_store[1] = {1'b0, aux[6:0]};
		frame_store[PACKET_LEN - 1] = frame_store[PACKET_LEN - 1] | SYNC_MASK;
		packet_number = packet_number + 6'd1;
		packets_predicted++;

		for (int k = 0; k < PACKET_LEN; k++) begin
			b.packet_byte = frame_store[k];
			b.last_byte   = (k == PACKET_LEN - 1);
			expected_bytes.push_back(b);
		end
	endtask

	// Send one sample request. Called and returning at a rising edge.
	// Hold push high across back-to-back requests; drop it only for a gap.
	task automatic send_sample(input logic [9:0] s, input logic fs, input logic [3:0] sw);
		int          gap;
		logic        ok;
		sample_req_t req;
		req.sample      = s;
		req.frame_start = fs;
		req.switches    = sw;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		// Sample full between edges, where it is settled
		forever begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
			if (ok)
				break;
		end
		samples_sent++;
		predict_packet(req);
	endtask

	// Pop side: after each byte, hold pop low for a random stall while idling is
	// on, and check every byte taken against the oldest expectation.
	initial begin : byte_checker
		logic      taken;
		int        stall;
		byte_req_t want;
		stall = 0;
		forever begin
			@(negedge clk);
			taken = (pop === 1'b1) && (empty === 1'b0);
			if (taken) begin
				if (expected_bytes.size() == 0) begin
					flag_mismatch($sformatf("unexpected byte %02h last=%b",
					                        result.packet_byte, result.last_byte));
				end else begin
					want = expected_bytes.pop_front();
					if (result.packet_byte !== want.packet_byte)
						flag_mismatch($sformatf("packet_byte expected %02h actual %02h",
						                        want.packet_byte, result.packet_byte));
					if (result.last_byte !== want.last_byte)
						flag_mismatch($sformatf("last_byte expected %b actual %b",
						                        want.last_byte, result.last_byte));
				end
				bytes_checked++;
			end
			@(posedge clk);
			if (taken)
				stall = idle_on ? $urandom_range(0, 3) : 0;
			else if (stall > 0)
				stall--;
			pop <= (arst_n && stall == 0);
		end
	end

	// Extremes: all-ones and all-zero frames, switch extremes, first packet
	// out of reset carrying the first ID character.
	task automatic test_extreme_frames();
		for (int c = 0; c < NUM_CHANNELS; c++)
			send_sample(10'h3FF, (c == 0), 4'hF);
		for (int c = 0; c < NUM_CHANNELS; c++)
			send_sample(10'h000, (c == 0), 4'h0);
	endtask

	// Frame restart: break a frame with a new frame start, then run a frame
	// whose channel zero carries no frame start flag.
	task automatic test_frame_restart();
		send_sample(10'h2AA, 1'b1, 4'h5);
		send_sample(10'h155, 1'b0, 4'hA);
		send_sample(10'h3C0, 1'b0, 4'h3);
		for (int c = 0; c < NUM_CHANNELS; c++)
			send_sample((c % 2) ? 10'h2AA : 10'h155, (c == 0), 4'hC);
		for (int c = 0; c < NUM_CHANNELS; c++)
			send_sample((c % 2) ? 10'h07F : 10'h380, 1'b0, 4'h9);
	endtask

	// Mostly well-formed frames with random content, some cut short by a
	// new frame start, some lone samples with a random frame start flag.
	task automatic test_random_traffic();
		int   pick;
		int   cut;
		int   items;
		logic force_start;
		items       = 0;
		force_start = 1'b1;
		while (items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 7) == 0)
				idle_on = !idle_on;
			if (pick < 80) begin
				for (int c = 0; c < NUM_CHANNELS; c++)
					send_sample(10'($urandom_range(0, 1023)),
					            (c == 0) && (force_start || ($urandom_range(0, 1) != 0)),
					            4'($urandom_range(0, 15)));
				items += NUM_CHANNELS;
				force_start = 1'b0;
			end else if (pick < 90) begin
				cut = $urandom_range(1, NUM_CHANNELS - 1);
				for (int c = 0; c < cut; c++)
					send_sample(10'($urandom_range(0, 1023)), (c == 0),
					            4'($urandom_range(0, 15)));
				items += cut;
				force_start = 1'b1;
			end else begin
				send_sample(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
				            4'($urandom_range(0, 15)));
				items++;
				force_start = 1'b1;
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin : run_sequence
		for (int k = 0; k < PACKET_LEN; k++)
			frame_store[k] = 8'h00;
		next_channel      = 0;
		packet_number     = '0;
		text_index        = '0;
		samples_sent      = 0;
		packets_predicted = 0;
		bytes_checked     = 0;
		mismatches        = 0;
		switch_packets    = 0;
		text_packets      = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_frames();
		test_frame_restart();
		test_random_traffic();

		push <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (expected_bytes.size() != 0)
			flag_mismatch($sformatf("%0d expected bytes never arrived",
			                        expected_bytes.size()));

		$display("Run: %0d samples, %0d packets, %0d bytes checked, %0d mismatches",
		         samples_sent, packets_predicted, bytes_checked, mismatches);
		$display("Aux: %0d ID-text packets, %0d switch packets, counter now %0d",
		         text_packets, switch_packets, packet_number);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire

### eeg_sample_packet_framer.f
hdl/espf_pkg.sv
hdl/espf_front.sv
hdl/espf_queue.sv
hdl/espf_back.sv
hdl/eeg_sample_packet_framer.sv
tb/sv/tb_top.sv
